/* sv/first_fit_block_allocator_defines.svh */
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FFBA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ffba assertion failed");
// expression must never be true outside reset
`define FFBA_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ffba forbidden condition seen");
`else
`define FFBA_ASSERT(lbl, prop)
`define FFBA_NEVER(lbl, expr)
`endif

`endif

/* sv/ffba_pkg.sv */
`default_nettype none

package ffba_pkg;

	localparam int HEAP_WORDS_DEF = 64;
	localparam int MAX_SIZE       = 127;
	localparam int MAX_RES        = 62;
	localparam logic [7:0] ALLOC_CLR_MASK = 8'b11111110;

	typedef enum logic [2:0] {
		ACT_ALLOC  = 3'd0,
		ACT_FREE   = 3'd1,
		ACT_WRITE  = 3'd2,
		ACT_READ   = 3'd3,
		ACT_HEADER = 3'd4,
		ACT_LIST   = 3'd5
	} act_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_COUNT    = 3'd3,
		ST_IDS      = 3'd4
	} status_t;

	// one result beat without the last flag
	typedef struct packed {
		status_t    status;
		logic [7:0] id;
		logic [7:0] ch;
		logic [6:0] words;
		logic       al;
		logic [5:0] start;
		logic [5:0] stop;
	} res_t;

endpackage

`default_nettype wire

/* sv/ffba_mem.sv */
`default_nettype none

module ffba_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter logic [7:0] RST1 = 8'd128
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          we,
	input  wire [AW-1:0] waddr,
	input  wire [7:0]    wdata,
	input  wire [AW-1:0] raddr,
	output logic [7:0]   rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rdata_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// written flags, unwritten words read as their reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (vld_q[raddr]) begin
			rdata_q <= mem[raddr];
		end else if (raddr == AW'(1)) begin
			rdata_q <= RST1;
		end else begin
			rdata_q <= 8'd0;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* sv/first_fit_block_allocator.sv */
// operation: a command walks block headers through states H0, H1, H2 and EV per block, then
// writes one fill word per cycle, reads each byte through RDI and RDE, or writes two or four
// header words in AWR for an alloc update; throughput: one command at a time, paced by the single
// read port of the heap memory
// reset: heap reads as one free block over the whole heap, next id is 1,
// control and output valid cleared asynchronously
`default_nettype none
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
	parameter int HEAP_WORDS = ffba_pkg::HEAP_WORDS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [2:0] action,
	input  wire  [7:0] request_size,
	input  wire  [7:0] block_id,
	input  wire  [7:0] fill_char,
	input  wire  [7:0] count,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] status,
	output logic [7:0] result_id,
	output logic [7:0] data_char,
	output logic [6:0] block_words,
	output logic       allocated,
	output logic [5:0] start_addr,
	output logic [5:0] end_addr,
	output logic       last
);
	import ffba_pkg::*;

	localparam int HEAP_LEN = (HEAP_WORDS < MAX_SIZE) ? HEAP_WORDS : MAX_SIZE;
	localparam int AW = $clog2(HEAP_WORDS);
	localparam int PW = $clog2(HEAP_LEN + 1);
	localparam logic [7:0] RST1 = 8'(HEAP_LEN << 1);

	typedef enum logic [3:0] {
		S_IDLE, S_H0, S_H1, S_H2, S_EV, S_AWR, S_FWR, S_RDI, S_RDE, S_LEMIT, S_EMIT
	} state_t;

	state_t      state_q;
	act_t        act_q;
	logic [7:0]  req_q, bid_q, ch_q, cnt_q;
	logic [PW-1:0] p_q;
	logic [7:0]  blk_id_q, blk_w_q;
	logic [7:0]  next_id_q;
	logic [7:0]  j_q;
	logic [5:0]  n_q;
	logic [1:0]  k_q;
	logic        split_q, pend_q;
	res_t        res_q, out_q;
	logic        out_valid_q, out_last_q;

	logic          mem_we;
	logic [8:0]    waddr9, raddr9;
	logic [7:0]    wdata, rdata;

	// header arithmetic on a 9-bit range
	logic [8:0] p9, s9, req9, cnt9, dsz9, nrd9, wsz9;
	logic       bad, fit, split, match, can_emit, walk_on, emit_go;
	res_t       blk_res, end_res, alloc_res, free_res, rd_res;

	// error beat with all block fields cleared
	function automatic res_t err_res(status_t st);
		res_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	assign p9    = 9'(p_q);
	assign s9    = 9'(blk_w_q[7:1]);
	assign req9  = 9'(req_q);
	assign cnt9  = 9'(cnt_q);
	assign dsz9  = s9 - 9'd2;
	assign bad   = (s9 < 9'd2) || (p9 + s9 > 9'(HEAP_LEN));
	assign fit   = !blk_w_q[0] && (s9 >= req9 + 9'd2);
	assign split = s9 > req9 + 9'd4;
	assign match = (bid_q != 8'd0) && (blk_id_q == bid_q);
	assign wsz9  = split ? req9 + 9'd2 : s9;
	assign can_emit = !out_valid_q || !out_stall;
	assign emit_go  = can_emit &&
		((state_q == S_RDE) || (state_q == S_LEMIT) || (state_q == S_EMIT));
	assign walk_on = (p9 + 9'd1 < 9'(HEAP_LEN)) &&
		!((act_q == ACT_LIST) && (n_q == 6'(MAX_RES)));

	// read length, min of count, data size and result cap
	always_comb begin
		nrd9 = (cnt9 < dsz9) ? cnt9 : dsz9;
		if (nrd9 > 9'(MAX_RES)) begin
			nrd9 = 9'(MAX_RES);
		end
	end

	// result images of the block under the walk pointer
	always_comb begin
		blk_res.status = ST_OK;
		blk_res.id     = blk_id_q;
		blk_res.ch     = 8'd0;
		blk_res.words  = blk_w_q[7:1];
		blk_res.al     = blk_w_q[0];
		blk_res.start  = 6'(p_q);
		blk_res.stop   = 6'(p9 + s9 - 9'd1);

		alloc_res       = blk_res;
		alloc_res.id    = next_id_q;
		alloc_res.words = 7'(wsz9);
		alloc_res.al    = 1'b1;
		alloc_res.stop  = 6'(p9 + wsz9 - 9'd1);

		free_res    = blk_res;
		free_res.al = 1'b0;

		rd_res    = res_q;
		rd_res.ch = rdata;

		case (act_q)
			ACT_ALLOC: end_res = err_res(ST_NOFIT);
			ACT_LIST:  end_res = pend_q ? res_q : res_t'('0);
			default:   end_res = err_res(ST_NOTFOUND);
		endcase
	end

	// memory port addressing
	always_comb begin
		mem_we = 1'b0;
		waddr9 = p9 + 9'd1;
		wdata  = blk_w_q & ALLOC_CLR_MASK;
		case (state_q)
			S_H0:    raddr9 = p9;
			S_H1:    raddr9 = p9 + 9'd1;
			default: raddr9 = p9 + 9'd2 + 9'(j_q);
		endcase
		case (state_q)
			S_EV: begin
				mem_we = !bad && (act_q == ACT_FREE) && match && blk_w_q[0];
			end
			S_AWR: begin
				mem_we = 1'b1;
				case (k_q)
					2'd0: begin
						waddr9 = p9 + req9 + 9'd2;
						wdata  = 8'd0;
					end
					2'd1: begin
						waddr9 = p9 + req9 + 9'd3;
						wdata  = {7'(s9 - req9 - 9'd2), 1'b0};
					end
					2'd2: begin
						waddr9 = p9 + 9'd1;
						wdata  = split_q ? {7'(req9 + 9'd2), 1'b1} : (blk_w_q | 8'd1);
					end
					default: begin
						waddr9 = p9;
						wdata  = next_id_q;
					end
				endcase
			end
			S_FWR: begin
				mem_we = (j_q != cnt_q);
				waddr9 = p9 + 9'd2 + 9'(j_q);
				wdata  = ch_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	ffba_mem #(
		.DEPTH(HEAP_WORDS),
		.AW(AW),
		.RST1(RST1)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.we(mem_we),
		.waddr(waddr9[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr9[AW-1:0]),
		.rdata(rdata)
	);

	// command sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_ALLOC;
			req_q       <= '0;
			bid_q       <= '0;
			ch_q        <= '0;
			cnt_q       <= '0;
			p_q         <= '0;
			blk_id_q    <= '0;
			blk_w_q     <= '0;
			next_id_q   <= 8'd1;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			split_q     <= 1'b0;
			pend_q      <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q  <= act_t'(action);
						req_q  <= request_size;
						bid_q  <= block_id;
						ch_q   <= fill_char;
						cnt_q  <= count;
						p_q    <= '0;
						n_q    <= '0;
						pend_q <= 1'b0;
						if (action > ACT_LIST) begin
							state_q <= S_IDLE;
						end else if ((action == ACT_ALLOC) && (next_id_q == 8'd0)) begin
							res_q   <= err_res(ST_IDS);
							state_q <= S_EMIT;
						end else begin
							state_q <= S_H0;
						end
					end
				end
				S_H0: begin
					if (walk_on) begin
						state_q <= S_H1;
					end else begin
						res_q   <= end_res;
						state_q <= S_EMIT;
					end
				end
				S_H1: begin
					blk_id_q <= rdata;
					state_q  <= S_H2;
				end
				S_H2: begin
					blk_w_q <= rdata;
					state_q <= S_EV;
				end
				S_EV: begin
					if (bad) begin
						res_q   <= end_res;
						state_q <= S_EMIT;
					end else begin
						case (act_q)
							ACT_ALLOC: begin
								if (fit) begin
									res_q   <= alloc_res;
									split_q <= split;
									k_q     <= split ? 2'd0 : 2'd2;
									state_q <= S_AWR;
								end else begin
									p_q     <= PW'(p9 + s9);
									state_q <= S_H0;
								end
							end
							ACT_LIST: begin
								if (pend_q) begin
									state_q <= S_LEMIT;
								end else begin
									res_q   <= blk_res;
									pend_q  <= 1'b1;
									n_q     <= 6'd1;
									p_q     <= PW'(p9 + s9);
									state_q <= S_H0;
								end
							end
							default: begin
								if (!match) begin
									p_q     <= PW'(p9 + s9);
									state_q <= S_H0;
								end else begin
									case (act_q)
										ACT_FREE: begin
											res_q   <= blk_w_q[0] ? free_res :
												err_res(ST_NOTFOUND);
											state_q <= S_EMIT;
										end
										ACT_WRITE: begin
											if (cnt9 > dsz9) begin
												res_q   <= err_res(ST_COUNT);
												state_q <= S_EMIT;
											end else begin
												res_q   <= blk_res;
												j_q     <= '0;
												state_q <= S_FWR;
											end
										end
										ACT_READ: begin
											res_q <= blk_res;
											if (nrd9 != 9'd0) begin
												n_q     <= 6'(nrd9);
												j_q     <= '0;
												state_q <= S_RDI;
											end else begin
												state_q <= S_EMIT;
											end
										end
										default: begin
											res_q   <= blk_res;
											state_q <= S_EMIT;
										end
									endcase
								end
							end
						endcase
					end
				end
				S_AWR: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						next_id_q <= next_id_q + 8'd1;
						state_q   <= S_EMIT;
					end
				end
				S_FWR: begin
					if (j_q == cnt_q) begin
						state_q <= S_EMIT;
					end else begin
						j_q <= j_q + 8'd1;
					end
				end
				S_RDI: begin
					state_q <= S_RDE;
				end
				S_RDE: begin
					if (can_emit) begin
						out_q       <= rd_res;
						out_last_q  <= (j_q == 8'(n_q - 6'd1));
						j_q         <= j_q + 8'd1;
						state_q     <= (j_q == 8'(n_q - 6'd1)) ? S_IDLE : S_RDI;
					end
				end
				S_LEMIT: begin
					if (can_emit) begin
						out_q       <= res_q;
						out_last_q  <= 1'b0;
						res_q       <= blk_res;
						n_q         <= n_q + 6'd1;
						p_q         <= PW'(p9 + s9);
						state_q     <= S_H0;
					end
				end
				S_EMIT: begin
					if (can_emit) begin
						out_q       <= res_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// ports
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign result_id   = out_q.id;
	assign data_char   = out_q.ch;
	assign block_words = out_q.words;
	assign allocated   = out_q.al;
	assign start_addr  = out_q.start;
	assign end_addr    = out_q.stop;
	assign last        = out_last_q;

	// checks
	`FFBA_ASSERT(a_id_step, (next_id_q != $past(next_id_q)) |-> (next_id_q == $past(next_id_q) + 8'd1))
	`FFBA_ASSERT(a_err_last, (out_valid && (status != ST_OK)) |-> last)
	`FFBA_NEVER(n_write_idle, mem_we && (state_q == S_IDLE))
	`FFBA_ASSERT(a_ids_gone, (in_valid && !in_stall && (action == ACT_ALLOC) && (next_id_q == 8'd0)) |=> (next_id_q == 8'd0))

endmodule

`default_nettype wire
